/* src/lzss_byte_stream_decompressor_unit_assert.svh */
// Assertion macros, clocked on aclk and held off during reset.
`ifndef LZSS_BYTE_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZSS_BYTE_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH

`define LZBS_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

`define LZBS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define LZBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lzbs_pkg.sv */
package lzbs_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int BYTE_W          = 8;
    localparam int COUNT_W         = 24;
    localparam int LEN_W           = 5;
    localparam int FLAGS_W         = 4;
    localparam int FLAGS_PER_CTRL  = 8;
    localparam int LEN_BIAS        = 2;

    typedef struct packed {
        logic clear;
        logic inc;
    } cnt_ctl_t;

    typedef struct packed {
        logic full;
        logic done_next;
    } cnt_stat_t;

endpackage

/* src/lzss_byte_stream_decompressor_unit.sv */
// LZSS decompressor, 4 KiB window: one compressed byte per s_ transfer, one
// decompressed byte per m_ transfer. The block takes an input byte only when
// its sequencer is idle. A control byte or match high byte passes only
// through DECODE, a literal through DECODE and EMIT, and a match low byte
// through DECODE, then READ and EMIT for each copied byte (length 2..17),
// since each copied byte is a window read then a write/emit; EMIT also waits
// while m_tready holds the output register. Restart needs no clearing pass:
// a fill count marks which window entries were written, others read as zero.
`include "lzss_byte_stream_decompressor_unit_assert.svh"

module lzss_byte_stream_decompressor_unit #(
    parameter int WINDOW_SIZE = lzbs_pkg::WINDOW_SIZE_DEF,
    localparam int AW = $clog2(WINDOW_SIZE)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [lzbs_pkg::COUNT_W-1:0] cfg_wdata, // byte limit of the stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lzbs_pkg::BYTE_W-1:0]  s_tdata,   // in_byte
    input  logic                         s_tuser,   // first_of_stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lzbs_pkg::BYTE_W-1:0]  m_tdata,   // out_byte
    output logic                         m_tlast,   // last_of_run
    output logic                         m_tuser    // output_done
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    localparam logic [1:0] PH_CONTROL   = 2'd0;
    localparam logic [1:0] PH_DATA      = 2'd1;
    localparam logic [1:0] PH_MATCH_LOW = 2'd2;

    localparam int BW = lzbs_pkg::BYTE_W;
    localparam int LW = lzbs_pkg::LEN_W;
    localparam int FLW = lzbs_pkg::FLAGS_W;

    logic [1:0]                   state_reg, state_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [BW-1:0]                byte_reg, byte_next;
    logic [BW-1:0]                flag_bits_reg, flag_bits_next;
    logic [FLW-1:0]               flags_left_reg, flags_left_next;
    logic [BW-1:0]                high_reg, high_next;
    logic [AW-1:0]                wp_reg, wp_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic [LW-1:0]                len_reg, len_next;
    logic                         lit_reg, lit_next;
    logic [lzbs_pkg::COUNT_W-1:0] size_reg;
    logic                         m_valid_reg, m_valid_next;
    logic [BW-1:0]                m_data_reg;
    logic                         m_last_reg;
    logic                         m_done_reg;

    logic                 in_xfer;
    logic                 out_free;
    logic                 emit_go;
    logic                 emit_last;
    logic [BW-1:0]        emit_byte;
    logic                 use_flag;
    logic                 win_clear;
    logic                 win_re;
    logic [BW-1:0]        win_rdata;
    lzbs_pkg::cnt_ctl_t   cnt_ctl;
    lzbs_pkg::cnt_stat_t  cnt_stat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign emit_go   = (state_reg == ST_EMIT) && out_free;
    assign emit_byte = lit_reg ? byte_reg : win_rdata;
    assign emit_last = lit_reg || (len_reg == LW'(1)) || cnt_stat.done_next;
    assign use_flag  = emit_go && emit_last;
    assign win_clear = in_xfer && s_tuser;
    assign win_re    = (state_reg == ST_READ);

    assign cnt_ctl.clear = win_clear;
    assign cnt_ctl.inc   = emit_go;

    lzbs_window #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (win_clear),
        .we      (emit_go),
        .waddr   (wp_reg),
        .wdata   (emit_byte),
        .re      (win_re),
        .raddr   (pos_reg),
        .rdata   (win_rdata)
    );

    lzbs_count u_count (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cnt_ctl),
        .size    (size_reg),
        .stat    (cnt_stat)
    );

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        byte_next       = byte_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        high_next       = high_reg;
        wp_next         = wp_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        lit_next        = lit_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    byte_next  = s_tdata;
                    state_next = ST_DECODE;
                    if (s_tuser) begin
                        wp_next         = AW'(1);
                        flag_bits_next  = '0;
                        flags_left_next = '0;
                        phase_next      = PH_CONTROL;
                        high_next       = '0;
                    end
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                if (cnt_stat.full) begin
                    state_next = ST_IDLE;
                end else if ((phase_reg == PH_CONTROL) || (flags_left_reg == '0)) begin
                    flag_bits_next  = byte_reg;
                    flags_left_next = FLW'(lzbs_pkg::FLAGS_PER_CTRL);
                    phase_next      = PH_DATA;
                end else if (phase_reg == PH_DATA) begin
                    if (flag_bits_reg[0]) begin
                        lit_next   = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        high_next  = byte_reg;
                        phase_next = PH_MATCH_LOW;
                    end
                end else begin
                    pos_next   = AW'({high_reg, byte_reg[7:4]});
                    len_next   = {1'b0, byte_reg[3:0]} + LW'(lzbs_pkg::LEN_BIAS);
                    lit_next   = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    wp_next    = wp_reg + AW'(1);
                    pos_next   = pos_reg + AW'(1);
                    len_next   = len_reg - LW'(1);
                    state_next = emit_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (use_flag) begin
            flag_bits_next  = {1'b0, flag_bits_reg[BW-1:1]};
            flags_left_next = flags_left_reg - FLW'(1);
            phase_next      = (flags_left_reg == FLW'(1)) ? PH_CONTROL : PH_DATA;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (emit_go) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_CONTROL;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            high_reg       <= '0;
            wp_reg         <= AW'(1);
            size_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            high_reg       <= high_next;
            wp_reg         <= wp_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        pos_reg  <= pos_next;
        len_reg  <= len_next;
        lit_reg  <= lit_next;
        if (emit_go) begin
            m_data_reg <= emit_byte;
            m_last_reg <= emit_last;
            m_done_reg <= cnt_stat.done_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_done_reg;

    `LZBS_ASSERT_IMPL(a_emit_only_when_free, emit_go, (!m_valid_reg || m_tready), "emit overwrote pending result")
    `LZBS_ASSERT_NEXT(a_done_stops_output, (emit_go && cnt_stat.done_next && !cfg_we), cnt_stat.full, "count not full after output_done")
    `LZBS_ASSERT_NOW(a_flags_bounded, (flags_left_reg <= FLW'(lzbs_pkg::FLAGS_PER_CTRL)), "flag count above eight")
    `LZBS_ASSERT_IMPL(a_match_len_range, (state_reg == ST_READ), ((len_reg != '0) && (len_reg <= LW'(17))), "match length out of range")

endmodule

/* src/lzbs_window.sv */
module lzbs_window #(
    parameter int WINDOW_SIZE = lzbs_pkg::WINDOW_SIZE_DEF,
    localparam int AW = $clog2(WINDOW_SIZE),
    localparam int FW = AW + 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [lzbs_pkg::BYTE_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [lzbs_pkg::BYTE_W-1:0] rdata
);

    logic [lzbs_pkg::BYTE_W-1:0] mem_reg [WINDOW_SIZE];
    logic [lzbs_pkg::BYTE_W-1:0] rd_data_reg;
    logic                        rd_valid_reg;
    logic [FW-1:0]               fill_reg;
    logic [FW-1:0]               fill_next;
    logic [AW-1:0]               rel_addr;

    // entries are written in order from address 1, so the fill count tells
    // which entries hold data since the last restart
    assign rel_addr = raddr - {{(AW-1){1'b0}}, 1'b1};

    always_comb begin
        fill_next = fill_reg;
        if (clear) begin
            fill_next = '0;
        end else if (we && (fill_reg != FW'(WINDOW_SIZE))) begin
            fill_next = fill_reg + {{(FW-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg  <= mem_reg[raddr];
            rd_valid_reg <= ({1'b0, rel_addr} < fill_reg);
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* src/lzbs_count.sv */
module lzbs_count (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lzbs_pkg::cnt_ctl_t           ctl,
    input  logic [lzbs_pkg::COUNT_W-1:0] size,
    output lzbs_pkg::cnt_stat_t          stat
);

    logic [lzbs_pkg::COUNT_W-1:0] produced_reg;
    logic [lzbs_pkg::COUNT_W-1:0] produced_next;
    logic [lzbs_pkg::COUNT_W-1:0] produced_inc;

    assign produced_inc = produced_reg + {{(lzbs_pkg::COUNT_W-1){1'b0}}, 1'b1};

    always_comb begin
        produced_next = produced_reg;
        if (ctl.clear) begin
            produced_next = '0;
        end else if (ctl.inc) begin
            produced_next = produced_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            produced_reg <= '0;
        end else begin
            produced_reg <= produced_next;
        end
    end

    assign stat.full      = (produced_reg >= size);
    assign stat.done_next = (produced_inc == size);

endmodule

/* tb/lzss_byte_stream_decompressor_unit_test.sv */
module lzss_byte_stream_decompressor_unit_test;
    import lzbs_pkg::*;

    localparam int RUN_LIMIT = 2_000_000;
    localparam int TAIL_WAIT = 60;
    localparam int HOLD_LEN  = 300;

    typedef enum logic [1:0] {WANT_CTRL, WANT_TOKEN, WANT_MATCH_LOW} parse_t;

    typedef struct {
        logic              first;
        logic [BYTE_W-1:0] data;
    } in_item_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              done;
    } out_rec_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [BYTE_W-1:0]  m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    lzss_byte_stream_decompressor_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // decoder state mirrored from the block
    logic [BYTE_W-1:0]  window_mem [0:WINDOW_SIZE_DEF-1];
    logic [11:0]        wr_pos;
    logic [7:0]         flag_reg;
    logic [FLAGS_W-1:0] flags_left;
    parse_t             phase;
    logic [7:0]         match_hi;
    logic [COUNT_W-1:0] produced;
    logic [COUNT_W-1:0] size_limit;

    in_item_t input_bytes[$];
    out_rec_t expected_bytes[$];
    out_rec_t got_rec;

    int          errors = 0;
    int          cycles = 0;
    int          items_queued = 0;
    logic        in_taken = 1'b0;
    bit          src_idle = 1'b1;
    bit          snk_idle = 1'b1;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          hold_asks = 0;
    int          hold_done = 0;
    int          hold_left = 0;
    logic [11:0] gen_pos = 12'd1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    task automatic clear_stream();
        foreach (window_mem[i])
            window_mem[i] = '0;
        wr_pos = 12'd1;
        flag_reg = '0;
        flags_left = '0;
        phase = WANT_CTRL;
        match_hi = '0;
        produced = '0;
    endtask

    task automatic put_byte(input logic [7:0] v);
        out_rec_t r;
        window_mem[wr_pos] = v;
        wr_pos++;
        produced++;
        r.data = v;
        r.last = 1'b0;
        r.done = (produced == size_limit);
        expected_bytes.insert(expected_bytes.size(), r);
    endtask

    task automatic take_flag();
        flag_reg = flag_reg >> 1;
        flags_left--;
        phase = (flags_left == 0) ? WANT_CTRL : WANT_TOKEN;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic restart);
        logic [11:0] src;
        int          len;
        int          n0;
        n0 = expected_bytes.size();
        if (restart)
            clear_stream();
        if (produced >= size_limit)
            return;
        if (phase == WANT_CTRL || flags_left == 0) begin
            flag_reg = b;
            flags_left = FLAGS_W'(FLAGS_PER_CTRL);
            phase = WANT_TOKEN;
        end else if (phase == WANT_TOKEN) begin
            if (flag_reg[0]) begin
                put_byte(b);
                take_flag();
            end else begin
                match_hi = b;
                phase = WANT_MATCH_LOW;
            end
        end else begin
            src = {match_hi, b[7:4]};
            len = b[3:0] + LEN_BIAS;
            while (len > 0 && produced < size_limit) begin
                put_byte(window_mem[src]);
                src++;
                len--;
            end
            take_flag();
        end
        if (expected_bytes.size() > n0)
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endtask

    // model update and result check
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
            clear_stream();
            size_limit = '0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (cfg_we)
                size_limit = cfg_wdata;
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("m_tdata: unexpected transfer, got %0h", m_tdata);
                    errors++;
                end else begin
                    got_rec = expected_bytes.pop_front();
                    if (m_tdata !== got_rec.data) begin
                        $error("m_tdata: expected %0h, got %0h", got_rec.data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== got_rec.last) begin
                        $error("m_tlast: expected %0b, got %0b", got_rec.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== got_rec.done) begin
                        $error("m_tuser: expected %0b, got %0b", got_rec.done, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    // input driver
    always @(negedge aclk) begin
        in_item_t it;
        if (aresetn) begin
            if (in_taken || !s_tvalid) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (input_bytes.size() != 0) begin
                    it = input_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= it.data;
                    s_tuser <= it.first;
                    src_gap = src_idle ? pick_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_done != hold_asks) begin
                hold_done = hold_asks;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                snk_gap = snk_idle ? pick_gap() : 0;
            end
        end
    end

    task automatic push_item(input logic [7:0] b, input logic first);
        in_item_t it;
        it.first = first;
        it.data = b;
        input_bytes.insert(input_bytes.size(), it);
        items_queued++;
    endtask

    task automatic push_stream(input int n_out, input bit restart);
        logic [7:0]  ctrl;
        logic [11:0] src;
        logic [3:0]  len;
        int          made;
        bit          lead;
        made = 0;
        lead = restart;
        if (restart)
            gen_pos = 12'd1;
        while (made < n_out) begin
            ctrl = 8'($urandom);
            push_item(ctrl, lead);
            lead = 1'b0;
            for (int k = 0; k < 8 && made < n_out; k++) begin
                if (ctrl[k]) begin
                    push_item(8'($urandom), 1'b0);
                    made++;
                    gen_pos++;
                end else begin
                    len = 4'($urandom);
                    if ($urandom_range(0, 4) != 0)
                        src = gen_pos - 12'($urandom_range(1, 40));
                    else
                        src = 12'($urandom);
                    push_item(src[11:4], 1'b0);
                    push_item({src[3:0], len}, 1'b0);
                    made += len + LEN_BIAS;
                    gen_pos = gen_pos + 12'(len) + 12'(LEN_BIAS);
                end
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge aclk);
        while (input_bytes.size() != 0 || s_tvalid || expected_bytes.size() != 0);
        repeat (TAIL_WAIT) @(posedge aclk);
    endtask

    task automatic write_size(input logic [COUNT_W-1:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [COUNT_W-1:0] sz;
        int                 target;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero size: everything ignored
        write_size('0);
        push_item(8'h5A, 1'b1);
        push_item(8'h81, 1'b0);
        wait_idle();

        // literals at both extremes, overlapping copy, top and bottom positions,
        // then a copy cut short by the size and ignored bytes afterwards
        write_size(24'd30);
        push_item(8'h03, 1'b1);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h1F, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'hF0, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h3F, 1'b0);
        push_item(8'hC3, 1'b0);
        push_item(8'h7E, 1'b0);
        wait_idle();

        // larger size resumes where parsing stopped
        write_size(24'd60);
        push_item(8'h00, 1'b0);
        push_item(8'h2A, 1'b0);
        push_item(8'h01, 1'b0);
        push_item(8'h05, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(8'h7F, 1'b0);
        wait_idle();

        // smaller size stops at once; restart then truncates a long copy
        write_size(24'd10);
        push_item(8'h11, 1'b0);
        push_item(8'hFE, 1'b1);
        push_item(8'h00, 1'b0);
        push_item(8'h0F, 1'b0);

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph % 4)
                0: sz = 24'hFFFFFF;
                1: sz = COUNT_W'($urandom_range(100, 3000));
                2: sz = COUNT_W'($urandom_range(1, 24));
                default: sz = COUNT_W'($urandom_range(25, 400));
            endcase
            if (ph == 6)
                sz = 24'd1;
            write_size(sz);
            src_idle = (ph != 3);
            snk_idle = (ph != 3 && ph != 5);
            target = items_queued + 46;
            while (items_queued < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 3))
                        push_item(8'($urandom), 1'($urandom_range(0, 1)));
                end else if (ph % 4 == 2) begin
                    push_stream($urandom_range(1, 30), 1'b1);
                end else begin
                    push_stream($urandom_range(1, 60), $urandom_range(0, 5) != 0);
                end
            end
            // receiver stalls long while the queue is still full
            if (ph == 1 || ph == 4)
                hold_asks++;
        end
        wait_idle();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
